/* hw/rtl/c2cyl_pkg.sv */
// Shared constants for the cartesian-to-cylindrical pose converter.
// Holds the Q30 arctangent table, fixed field widths and default parameters.
// No dependencies.
package c2cyl_pkg;

  localparam int COORD_W   = 24;
  localparam int TIP_W     = 18;
  localparam int RAD_W     = 24;
  localparam int ANG_OUT_W = 16;

  // CORDIC datapath: x/y carry growth of ~1.65*sqrt(2), z is Q30 plus +-pi base
  localparam int CW = 27;
  localparam int ZW = 34;

  // radius: 48-bit sum of squares, one root bit per stage
  localparam int SQ_W       = 48;
  localparam int SQRT_STEPS = 24;

  localparam int TABLE_LEN = 24;

  localparam int DEF_ANGLE_FRAC_BITS = 13;
  localparam int DEF_CORDIC_STAGES   = 16;

  localparam longint Q30_PI = 64'sd3373259426;

  // atan(2^-i) in Q30, truncated
  localparam logic [31:0] ATAN_TABLE [TABLE_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  // smallest j with two_pi * 2^j covering the tip angle magnitude
  function automatic int tip_shift(longint two_pi, int tip_w);
    int j;
    j = 0;
    for (int i = 0; i < 32; i++) begin
      if ((two_pi <<< i) < (64'sd1 <<< (tip_w - 1))) j = i + 1;
    end
    return j;
  endfunction

endpackage

/* hw/rtl/cartesian_to_cylindrical_ik.sv */
// Pose converter: radius = sqrt(x^2+y^2), arm = atan2(y,x), hand = tip + arm wrapped.
// Registers in order: S0 input, S1, S2, the iteration stages, P1, P2, P3 and P4 (output).
// Throughput one request per cycle; busy stays low, the receiver cannot stall.
// The iteration stages form the 24-stage root/CORDIC pipeline (one root bit per stage).
// Synchronous active-low reset clears the valid bits only; depends on c2cyl_pkg.
module cartesian_to_cylindrical_ik
  import c2cyl_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
  parameter int CORDIC_STAGES   = DEF_CORDIC_STAGES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [COORD_W-1:0]   in_x_coord,
  input  logic signed [COORD_W-1:0]   in_y_coord,
  input  logic signed [COORD_W-1:0]   in_z_coord,
  input  logic signed [TIP_W-1:0]     in_tip_angle,
  output logic                        out_valid,
  output logic [RAD_W-1:0]            out_radius,
  output logic signed [ANG_OUT_W-1:0] out_arm_angle,
  output logic signed [COORD_W-1:0]   out_height,
  output logic signed [ANG_OUT_W-1:0] out_hand_angle
);

  localparam int     RND_SH   = 30 - ANGLE_FRAC_BITS;
  localparam longint PI_Q     = (Q30_PI + (64'sd1 <<< (RND_SH - 1))) >>> RND_SH;
  localparam longint TWO_PI_Q = 2 * PI_Q;
  localparam int     TIP_J    = tip_shift(TWO_PI_Q, TIP_W);
  localparam int     UW       = $clog2(TWO_PI_Q) + TIP_J + 2;
  localparam int     AW       = $clog2(PI_Q + 1) + 1;
  localparam int     HW       = ((AW > TIP_W) ? AW : TIP_W) + 2;

  typedef struct packed {
    logic signed [CW-1:0]      x;
    logic signed [CW-1:0]      y;
    logic signed [ZW-1:0]      z;
    logic [SQ_W-1:0]           rem;
    logic [SQ_W-1:0]           root;
    logic [UW-1:0]             tip_u;
    logic signed [TIP_W-1:0]   tip;
    logic signed [COORD_W-1:0] height;
    logic                      on_axis;
    logic                      x_neg;
    logic                      y_pos;
  } iter_t;

  assign busy = 1'b0;

  // ---------------- S0: input register
  logic                      s0_vld_r;
  logic signed [COORD_W-1:0] s0_x_r, s0_y_r, s0_z_r;
  logic signed [TIP_W-1:0]   s0_tip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s0_vld_r <= 1'b0;
    else        s0_vld_r <= start;
  end

  always_ff @(posedge clk) begin
    s0_x_r   <= in_x_coord;
    s0_y_r   <= in_y_coord;
    s0_z_r   <= in_z_coord;
    s0_tip_r <= in_tip_angle;
  end

  // ---------------- S1: squares, half-plane fold, tip offset
  logic                      s1_vld_r;
  logic [SQ_W-2:0]           s1_xsq_r, s1_ysq_r;
  iter_t                     s1_r, s1_nxt;
  logic signed [SQ_W-1:0]    xprod, yprod;
  logic signed [UW:0]        tip_off;

  always_comb begin
    xprod = s0_x_r * s0_x_r;
    yprod = s0_y_r * s0_y_r;
    tip_off = (UW+1)'(s0_tip_r) + (UW+1)'(TWO_PI_Q <<< TIP_J);
    s1_nxt         = '0;
    s1_nxt.on_axis = (s0_y_r == '0);
    s1_nxt.x_neg   = s0_x_r[COORD_W-1];
    s1_nxt.y_pos   = !s0_y_r[COORD_W-1];
    // left half plane: rotate by pi, base angle added back at the end
    s1_nxt.x       = s0_x_r[COORD_W-1] ? -CW'(s0_x_r) : CW'(s0_x_r);
    s1_nxt.y       = s0_x_r[COORD_W-1] ? -CW'(s0_y_r) : CW'(s0_y_r);
    s1_nxt.tip_u   = tip_off[UW-1:0];
    s1_nxt.tip     = s0_tip_r;
    s1_nxt.height  = s0_z_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= s0_vld_r;
  end

  always_ff @(posedge clk) begin
    s1_xsq_r <= xprod[SQ_W-2:0];
    s1_ysq_r <= yprod[SQ_W-2:0];
    s1_r     <= s1_nxt;
  end

  // ---------------- S2: sum of squares, enters iteration pipe
  logic  pipe_vld_r [0:SQRT_STEPS];
  iter_t pipe_r     [0:SQRT_STEPS];
  iter_t pipe0_nxt;

  always_comb begin
    pipe0_nxt      = s1_r;
    pipe0_nxt.rem  = SQ_W'(s1_xsq_r) + SQ_W'(s1_ysq_r);
    pipe0_nxt.root = '0;
    pipe0_nxt.z    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pipe_vld_r[0] <= 1'b0;
    else        pipe_vld_r[0] <= s1_vld_r;
  end

  always_ff @(posedge clk) begin
    pipe_r[0] <= pipe0_nxt;
  end

  // ---------------- iteration stages: root bit, CORDIC step, tip reduction step
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_iter
    localparam logic [SQ_W-1:0] RBIT = SQ_W'(1) << (SQ_W - 2 - 2*k);
    iter_t           stg_nxt;
    logic [SQ_W-1:0] trial;
    logic [UW-1:0]   tip_nxt;
    logic signed [CW-1:0] x_nxt, y_nxt;
    logic signed [ZW-1:0] z_nxt;

    always_comb begin
      trial = pipe_r[k].root + RBIT;
      stg_nxt = pipe_r[k];
      if (pipe_r[k].rem >= trial) begin
        stg_nxt.rem  = pipe_r[k].rem - trial;
        stg_nxt.root = (pipe_r[k].root >> 1) + RBIT;
      end else begin
        stg_nxt.root = pipe_r[k].root >> 1;
      end
      stg_nxt.x     = x_nxt;
      stg_nxt.y     = y_nxt;
      stg_nxt.z     = z_nxt;
      stg_nxt.tip_u = tip_nxt;
    end

    if (k < CORDIC_STAGES && k < TABLE_LEN) begin : g_rot
      logic signed [CW-1:0] xs, ys;
      always_comb begin
        xs = pipe_r[k].x >>> k;
        ys = pipe_r[k].y >>> k;
        if (!pipe_r[k].y[CW-1]) begin
          x_nxt = pipe_r[k].x + ys;
          y_nxt = pipe_r[k].y - xs;
          z_nxt = pipe_r[k].z + ZW'(ATAN_TABLE[k]);
        end else begin
          x_nxt = pipe_r[k].x - ys;
          y_nxt = pipe_r[k].y + xs;
          z_nxt = pipe_r[k].z - ZW'(ATAN_TABLE[k]);
        end
      end
    end else begin : g_norot
      assign x_nxt = pipe_r[k].x;
      assign y_nxt = pipe_r[k].y;
      assign z_nxt = pipe_r[k].z;
    end

    if (k <= TIP_J) begin : g_tip
      localparam logic [UW-1:0] TSUB = UW'(TWO_PI_Q <<< (TIP_J - k));
      assign tip_nxt = (pipe_r[k].tip_u >= TSUB) ? pipe_r[k].tip_u - TSUB
                                                 : pipe_r[k].tip_u;
    end else begin : g_notip
      assign tip_nxt = pipe_r[k].tip_u;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) pipe_vld_r[k+1] <= 1'b0;
      else        pipe_vld_r[k+1] <= pipe_vld_r[k];
    end

    always_ff @(posedge clk) begin
      pipe_r[k+1] <= stg_nxt;
    end
  end

  // ---------------- P1: base angle and clamp, root rounding, tip into (-pi, pi]
  localparam int LAST = SQRT_STEPS;

  logic                      p1_vld_r;
  logic signed [ZW-1:0]      p1_z_r;
  logic [RAD_W-1:0]          p1_rad_r;
  logic signed [AW-1:0]      p1_tipr_r;
  logic signed [TIP_W-1:0]   p1_tip_r;
  logic signed [COORD_W-1:0] p1_height_r;
  logic                      p1_on_axis_r, p1_x_neg_r;

  logic signed [ZW-1:0]      base, zb, z_nxt;
  logic signed [UW:0]        tipw;
  logic [RAD_W-1:0]          rad_nxt;

  always_comb begin
    base = '0;
    if (pipe_r[LAST].x_neg) begin
      base = pipe_r[LAST].y_pos ? ZW'(Q30_PI) : -ZW'(Q30_PI);
    end
    zb = pipe_r[LAST].z + base;
    z_nxt = zb;
    if (zb > ZW'(Q30_PI))  z_nxt = ZW'(Q30_PI);
    if (zb < -ZW'(Q30_PI)) z_nxt = -ZW'(Q30_PI);

    rad_nxt = pipe_r[LAST].root[RAD_W-1:0]
            + RAD_W'(pipe_r[LAST].rem > pipe_r[LAST].root);

    tipw = $signed({1'b0, pipe_r[LAST].tip_u});
    if (tipw > (UW+1)'(PI_Q)) tipw = tipw - (UW+1)'(TWO_PI_Q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) p1_vld_r <= 1'b0;
    else        p1_vld_r <= pipe_vld_r[LAST];
  end

  always_ff @(posedge clk) begin
    p1_z_r       <= z_nxt;
    p1_rad_r     <= rad_nxt;
    p1_tipr_r    <= AW'(tipw);
    p1_tip_r     <= pipe_r[LAST].tip;
    p1_height_r  <= pipe_r[LAST].height;
    p1_on_axis_r <= pipe_r[LAST].on_axis;
    p1_x_neg_r   <= pipe_r[LAST].x_neg;
  end

  // ---------------- P2: round Q30 to output format, axis override
  logic                      p2_vld_r;
  logic signed [AW-1:0]      p2_arm_r, p2_tipr_r;
  logic signed [TIP_W-1:0]   p2_tip_r;
  logic [RAD_W-1:0]          p2_rad_r;
  logic signed [COORD_W-1:0] p2_height_r;

  logic signed [ZW-1:0]      zr;
  logic signed [AW-1:0]      arm_nxt;

  always_comb begin
    zr = p1_z_r + ZW'(64'sd1 <<< (RND_SH - 1));
    arm_nxt = AW'(zr >>> RND_SH);
    // on the x axis (and at the origin) the angle is exact
    if (p1_on_axis_r) arm_nxt = p1_x_neg_r ? AW'(PI_Q) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) p2_vld_r <= 1'b0;
    else        p2_vld_r <= p1_vld_r;
  end

  always_ff @(posedge clk) begin
    p2_arm_r    <= arm_nxt;
    p2_tipr_r   <= p1_tipr_r;
    p2_tip_r    <= p1_tip_r;
    p2_rad_r    <= p1_rad_r;
    p2_height_r <= p1_height_r;
  end

  // ---------------- P3: raw and reduced hand sums, wrap direction
  logic                      p3_vld_r;
  logic signed [HW-1:0]      p3_h_r, p3_hp_r;
  logic                      p3_gt_r, p3_lt_r;
  logic signed [AW-1:0]      p3_arm_r;
  logic [RAD_W-1:0]          p3_rad_r;
  logic signed [COORD_W-1:0] p3_height_r;

  logic signed [HW-1:0]      h_nxt, hp_nxt;

  always_comb begin
    h_nxt  = HW'(p2_tip_r) + HW'(p2_arm_r);
    hp_nxt = HW'(p2_tipr_r) + HW'(p2_arm_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) p3_vld_r <= 1'b0;
    else        p3_vld_r <= p2_vld_r;
  end

  always_ff @(posedge clk) begin
    p3_h_r      <= h_nxt;
    p3_hp_r     <= hp_nxt;
    p3_gt_r     <= (h_nxt > HW'(PI_Q));
    p3_lt_r     <= (h_nxt < -HW'(PI_Q));
    p3_arm_r    <= p2_arm_r;
    p3_rad_r    <= p2_rad_r;
    p3_height_r <= p2_height_r;
  end

  // ---------------- P4: wrap and output register
  // wrapping down lands in (-pi, pi], wrapping up in [-pi, pi)
  logic                        out_valid_r;
  logic [RAD_W-1:0]            out_radius_r;
  logic signed [ANG_OUT_W-1:0] out_arm_r, out_hand_r;
  logic signed [COORD_W-1:0]   out_height_r;

  logic signed [HW-1:0]        hand_nxt;

  always_comb begin
    hand_nxt = p3_h_r;
    if (p3_gt_r) begin
      if (p3_hp_r > HW'(PI_Q))        hand_nxt = p3_hp_r - HW'(TWO_PI_Q);
      else if (p3_hp_r <= -HW'(PI_Q)) hand_nxt = p3_hp_r + HW'(TWO_PI_Q);
      else                            hand_nxt = p3_hp_r;
    end else if (p3_lt_r) begin
      if (p3_hp_r >= HW'(PI_Q))       hand_nxt = p3_hp_r - HW'(TWO_PI_Q);
      else if (p3_hp_r < -HW'(PI_Q))  hand_nxt = p3_hp_r + HW'(TWO_PI_Q);
      else                            hand_nxt = p3_hp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= p3_vld_r;
  end

  always_ff @(posedge clk) begin
    out_radius_r <= p3_rad_r;
    out_arm_r    <= ANG_OUT_W'(p3_arm_r);
    out_hand_r   <= ANG_OUT_W'(hand_nxt);
    out_height_r <= p3_height_r;
  end

  assign out_valid      = out_valid_r;
  assign out_radius     = out_radius_r;
  assign out_arm_angle  = out_arm_r;
  assign out_height     = out_height_r;
  assign out_hand_angle = out_hand_r;

endmodule

/* tb/cartesian_to_cylindrical_ik_tb.sv */
// Self-checking bench for the cartesian_to_cylindrical_ik pose converter.
// Predicts radius, atan2 and wrapped hand angle per request; depends on c2cyl_pkg and the DUT.
`timescale 1ns / 1ps

module cartesian_to_cylindrical_ik_tb
  import c2cyl_pkg::*;
();

  localparam int     ANGLE_FRAC     = DEF_ANGLE_FRAC_BITS;
  localparam int     STAGES         = DEF_CORDIC_STAGES;
  localparam int     ANGLE_SHIFT    = 30 - ANGLE_FRAC;
  localparam longint PI_Q30         = Q30_PI;
  localparam int     TAIL_CYCLES    = 40;
  localparam int     WATCHDOG_LIMIT = 2000;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [TIP_W-1:0]   TIP_MAX   = {1'b0, {(TIP_W-1){1'b1}}};
  localparam logic signed [TIP_W-1:0]   TIP_MIN   = {1'b1, {(TIP_W-1){1'b0}}};

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic signed [TIP_W-1:0]   tip;
  } pose_t;

  typedef struct {
    logic [RAD_W-1:0]            radius;
    logic signed [ANG_OUT_W-1:0] arm;
    logic signed [COORD_W-1:0]   height;
    logic signed [ANG_OUT_W-1:0] hand;
  } cyl_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic signed [COORD_W-1:0]   in_x_coord = '0;
  logic signed [COORD_W-1:0]   in_y_coord = '0;
  logic signed [COORD_W-1:0]   in_z_coord = '0;
  logic signed [TIP_W-1:0]     in_tip_angle = '0;
  logic                        out_valid;
  logic [RAD_W-1:0]            out_radius;
  logic signed [ANG_OUT_W-1:0] out_arm_angle;
  logic signed [COORD_W-1:0]   out_height;
  logic signed [ANG_OUT_W-1:0] out_hand_angle;

  pose_t pending_poses[$];
  cyl_t  expected_cyl[$];
  pose_t cur_pose;
  int    idle_pct = 0;
  int    poses_sent = 0;
  int    results_checked = 0;
  int    mismatches = 0;
  int    quiet_cycles = 0;

  cartesian_to_cylindrical_ik #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC),
    .CORDIC_STAGES  (STAGES)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_x_coord    (in_x_coord),
    .in_y_coord    (in_y_coord),
    .in_z_coord    (in_z_coord),
    .in_tip_angle  (in_tip_angle),
    .out_valid     (out_valid),
    .out_radius    (out_radius),
    .out_arm_angle (out_arm_angle),
    .out_height    (out_height),
    .out_hand_angle(out_hand_angle)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // atan(2^-i) in Q30, truncated
  function automatic longint atan_step(int i);
    case (i)
      0:  return 64'h3243F6A8;
      1:  return 64'h1DAC6705;
      2:  return 64'h0FADBAFC;
      3:  return 64'h07F56EA6;
      4:  return 64'h03FEAB76;
      5:  return 64'h01FFD55B;
      6:  return 64'h00FFFAAA;
      7:  return 64'h007FFF55;
      8:  return 64'h003FFFEA;
      9:  return 64'h001FFFFD;
      10: return 64'h000FFFFF;
      11: return 64'h0007FFFF;
      12: return 64'h0003FFFF;
      13: return 64'h0001FFFF;
      14: return 64'h0000FFFF;
      15: return 64'h00007FFF;
      16: return 64'h00003FFF;
      17: return 64'h00001FFF;
      18: return 64'h00000FFF;
      19: return 64'h000007FF;
      20: return 64'h000003FF;
      21: return 64'h000001FF;
      22: return 64'h000000FF;
      default: return 64'h0000007F;
    endcase
  endfunction

  // integer square root, rounded to nearest via the remainder
  function automatic longint unsigned root_round(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (n > r) r = r + 1;
    return r;
  endfunction

  // vectoring CORDIC, Q30 radians, clamped to +-pi
  function automatic longint cordic_atan2(longint xv, longint yv);
    longint base_ang;
    longint acc;
    longint xs;
    longint ys;
    base_ang = 0;
    acc = 0;
    if (yv == 0) return (xv < 0) ? PI_Q30 : 64'sd0;
    if (xv < 0) begin
      base_ang = (yv >= 0) ? PI_Q30 : -PI_Q30;
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < STAGES && i < TABLE_LEN; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (yv >= 0) begin
        xv = xv + ys;
        yv = yv - xs;
        acc = acc + atan_step(i);
      end else begin
        xv = xv - ys;
        yv = yv + xs;
        acc = acc - atan_step(i);
      end
    end
    acc = acc + base_ang;
    if (acc > PI_Q30) acc = PI_Q30;
    if (acc < -PI_Q30) acc = -PI_Q30;
    return acc;
  endfunction

  function automatic longint angle_round(longint v);
    return (v + (64'sd1 <<< (ANGLE_SHIFT - 1))) >>> ANGLE_SHIFT;
  endfunction

  function automatic cyl_t cylinder_of(pose_t p);
    cyl_t   c;
    longint xv;
    longint yv;
    longint arm;
    longint hand;
    longint pi_q;
    longint unsigned sq;
    longint unsigned rad;
    xv = p.x;
    yv = p.y;
    sq = xv * xv + yv * yv;
    rad = root_round(sq);
    pi_q = angle_round(PI_Q30);
    arm = angle_round(cordic_atan2(xv, yv));
    hand = longint'(p.tip) + arm;
    while (hand > pi_q) hand = hand - 2 * pi_q;
    while (hand < -pi_q) hand = hand + 2 * pi_q;
    c.radius = rad[RAD_W-1:0];
    c.arm = arm[ANG_OUT_W-1:0];
    c.height = p.z;
    c.hand = hand[ANG_OUT_W-1:0];
    return c;
  endfunction

  function automatic logic signed [COORD_W-1:0] edge_coord();
    case ($urandom_range(0, 4))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return COORD_W'(-1);
      3: return COORD_W'(1);
      default: return '0;
    endcase
  endfunction

  function automatic pose_t random_pose();
    pose_t p;
    int unsigned r;
    int style;
    style = $urandom_range(0, 9);
    r = $urandom(); p.x = r[COORD_W-1:0];
    r = $urandom(); p.y = r[COORD_W-1:0];
    r = $urandom(); p.z = r[COORD_W-1:0];
    r = $urandom(); p.tip = r[TIP_W-1:0];
    case (style)
      5, 6: begin
        p.x = COORD_W'(int'($urandom_range(0, 512)) - 256);
        p.y = COORD_W'(int'($urandom_range(0, 512)) - 256);
      end
      7: begin
        if ($urandom_range(0, 1)) p.x = '0;
        else p.y = '0;
        if ($urandom_range(0, 3) == 0) p.y = '0;
      end
      8: begin
        p.x = edge_coord();
        p.y = edge_coord();
      end
      9: begin
        // close to the negative x axis, where the angle can overshoot pi
        p.x = COORD_W'(-longint'($urandom_range(1, 8388608)));
        p.y = COORD_W'(int'($urandom_range(0, 8)) - 4);
      end
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0: p.tip = TIP_MAX;
      1: p.tip = TIP_MIN;
      default: ;
    endcase
    return p;
  endfunction

  task automatic add_pose(input longint x, input longint y, input longint z, input longint tip);
    pose_t p;
    p.x = COORD_W'(x);
    p.y = COORD_W'(y);
    p.z = COORD_W'(z);
    p.tip = TIP_W'(tip);
    pending_poses.push_back(p);
  endtask

  task automatic drain_all();
    while (pending_poses.size() != 0 || start || expected_cyl.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int count, input int pct);
    idle_pct = pct;
    repeat (count) pending_poses.push_back(random_pose());
    drain_all();
  endtask

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // driver: predict on acceptance, then present the next request or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_cyl.push_back(cylinder_of(cur_pose));
        poses_sent++;
      end
      if (!start || !busy) begin
        if (pending_poses.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          cur_pose = pending_poses.pop_front();
          start <= 1'b1;
          in_x_coord <= cur_pose.x;
          in_y_coord <= cur_pose.y;
          in_z_coord <= cur_pose.z;
          in_tip_angle <= cur_pose.tip;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cyl_t want;
    if (rst_n && out_valid) begin
      if (expected_cyl.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual radius %0d arm %0d height %0d hand %0d",
                 $time, out_radius, out_arm_angle, out_height, out_hand_angle);
        mismatches++;
      end else begin
        want = expected_cyl.pop_front();
        check_field("radius", want.radius, out_radius);
        check_field("arm_angle", want.arm, out_arm_angle);
        check_field("height", want.height, out_height);
        check_field("hand_angle", want.hand, out_hand_angle);
        results_checked++;
      end
    end
  end

  // watchdog on cycles with no request or result taken
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, expected_cyl.size());
      $display("cartesian_to_cylindrical_ik regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (!rst_n) @(negedge clk);
    @(negedge clk);

    idle_pct = 0;
    add_pose(0, 0, 0, 0);                       // origin
    add_pose(256, 0, COORD_MAX, 0);             // positive x axis
    add_pose(-256, 0, COORD_MIN, 0);            // negative x axis gives +pi
    add_pose(0, 256, 1, 100);
    add_pose(0, -256, -1, -100);
    add_pose(COORD_MAX, COORD_MAX, COORD_MAX, TIP_MAX);
    add_pose(COORD_MIN, COORD_MIN, COORD_MIN, TIP_MIN);
    add_pose(COORD_MIN, COORD_MAX, 0, TIP_MAX);
    add_pose(COORD_MAX, COORD_MIN, 0, TIP_MIN);
    add_pose(COORD_MIN, 0, 12345, 0);
    add_pose(COORD_MIN, 1, 0, 0);               // overshoot side of +pi
    add_pose(COORD_MIN, -1, 0, 0);              // overshoot side of -pi
    add_pose(-1, 1, 0, 0);
    add_pose(-1, -1, 0, 0);
    add_pose(1, 1, 0, 0);
    add_pose(1, -1, 0, 0);
    add_pose(-256, 0, 0, TIP_MAX);              // hand needs several wraps
    add_pose(-256, -1, 0, TIP_MIN);
    add_pose(0, COORD_MIN, 0, -1);
    add_pose(COORD_MAX, 0, 0, 1);
    add_pose(0, COORD_MAX, 0, 25736);
    add_pose(-3000, 2000, -5000, -25736);
    drain_all();

    run_phase(400, 0);
    run_phase(400, 59);
    run_phase(400, 15);
    run_phase(300, 0);

    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d poses (directed extremes and axes, then random at 0/59/15/0 pct idle);",
             poses_sent);
    $display("checked %0d results, %0d mismatches, %0d still expected.",
             results_checked, mismatches, expected_cyl.size());
    if (mismatches == 0 && expected_cyl.size() == 0) begin
      $display("cartesian_to_cylindrical_ik regression: pass");
    end else begin
      $display("cartesian_to_cylindrical_ik regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/c2cyl_pkg.sv
hw/rtl/cartesian_to_cylindrical_ik.sv
tb/cartesian_to_cylindrical_ik_tb.sv
